/* rtl/chb_pkg.sv */
// Shared types, character codes and result codes for the chunked body decoder.
// No dependencies; the front end, queue, core, top level and checker import it.
package chb_pkg;

	localparam int SIZE_BITS   = 32;
	localparam int LENGTH_BITS = 32;
	localparam int LEN_OUT_BITS = 32;

	localparam int QDEPTH = 4;
	localparam int QA_BITS = $clog2(QDEPTH);
	localparam int QC_BITS = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_CR   = 8'd13;
	localparam logic [7:0] CH_LF   = 8'd10;
	localparam logic [7:0] CH_SEMI = 8'd59;

	localparam logic ACT_BYTE    = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	localparam logic [1:0] KIND_DATA     = 2'd0;
	localparam logic [1:0] KIND_COMPLETE = 2'd1;
	localparam logic [1:0] KIND_ERROR    = 2'd2;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_BAD_SIZE = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW = 2'd2;
	localparam logic [1:0] ERR_DATA_END = 2'd3;

	// line_match meanings: size line verdict, data end CR seen, trailer match count
	localparam logic [1:0] LM_GOOD   = 2'd0;
	localparam logic [1:0] LM_BAD    = 2'd1;
	localparam logic [1:0] LM_OVF    = 2'd2;
	localparam logic [1:0] LM_NONE   = 2'd0;
	localparam logic [1:0] LM_CR     = 2'd1;
	localparam logic [1:0] LM_CRLF   = 2'd2;
	localparam logic [1:0] LM_CRLFCR = 2'd3;

	typedef struct packed {
		logic       restart;
		logic       is_cr;
		logic       is_lf;
		logic       is_semi;
		logic       is_hex;
		logic [3:0] hex_val;
		logic [7:0] data;
	} chb_item_t;

	typedef enum logic [7:0] {
		ST_SIZE    = 8'b0000_0001,
		ST_SIZE_CR = 8'b0000_0010,
		ST_EXT     = 8'b0000_0100,
		ST_EXT_CR  = 8'b0000_1000,
		ST_DATA    = 8'b0001_0000,
		ST_DATA_CR = 8'b0010_0000,
		ST_DATA_LF = 8'b0100_0000,
		ST_TRAILER = 8'b1000_0000
	} chb_state_t;

	// {valid, value} of an ASCII hex digit
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

endpackage

/* rtl/chb_in_if.sv */
// Input channel of the chunked body decoder: valid/ready plus an action and one body byte.
// No dependencies.
interface chb_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;

	modport source(output valid, action, data_byte, input ready);
	modport sink(input valid, action, data_byte, output ready);
endinterface

/* rtl/chb_out_if.sv */
// Result channel of the chunked body decoder: valid/ready plus one result.
// No dependencies.
interface chb_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [1:0]  error_code;
	logic [31:0] decoded_length;

	modport source(output valid, kind, payload_byte, error_code, decoded_length,
		input ready);
	modport sink(input valid, kind, payload_byte, error_code, decoded_length,
		output ready);
endinterface

/* rtl/chb_front.sv */
// Front end: accepts input transactions and classifies each byte.
// Depends on chb_pkg and chb_in_if.
module chb_front
	import chb_pkg::*;
(
	chb_in_if.sink    body_in,
	input  logic      q_full,
	output logic      push,
	output chb_item_t push_item
);
	logic [4:0] hx;

	assign hx = hex_decode(body_in.data_byte);

	assign body_in.ready = !q_full;
	assign push          = body_in.valid && !q_full;

	always_comb begin
		push_item.restart = (body_in.action == ACT_RESTART);
		push_item.is_cr   = (body_in.data_byte == CH_CR);
		push_item.is_lf   = (body_in.data_byte == CH_LF);
		push_item.is_semi = (body_in.data_byte == CH_SEMI);
		push_item.is_hex  = hx[4];
		push_item.hex_val = hx[3:0];
		push_item.data    = body_in.data_byte;
	end
endmodule

/* rtl/chb_queue.sv */
// Short queue of classified bytes between front end and decoder core.
// Depends on chb_pkg.
module chb_queue
	import chb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  chb_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      pop_valid,
	output chb_item_t pop_item
);
	chb_item_t          mem_q [QDEPTH];
	logic [QA_BITS-1:0] wr_ptr_q;
	logic [QA_BITS-1:0] rd_ptr_q;
	logic [QC_BITS-1:0] count_q;
	logic               do_pop;

	assign full      = (count_q == QC_BITS'(QDEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QA_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QA_BITS'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + QC_BITS'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - QC_BITS'(1);
			end
		end
	end
endmodule

/* rtl/chb_back.sv */
// Decoder core: runs the chunk state machine on classified bytes and holds
// the result register. Depends on chb_pkg and chb_out_if.
module chb_back
	import chb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  chb_item_t  q_item,
	output logic       pop,
	chb_out_if.source  result_out
);
	chb_state_t           st_q, st_d;
	logic [SIZE_BITS-1:0] acc_q, acc_d;
	logic [SIZE_BITS-1:0] left_q, left_d;
	logic [LENGTH_BITS-1:0] tot_q, tot_d;
	logic                 seen_q, seen_d;
	logic [1:0]           lm_q, lm_d;
	logic                 stop_q, stop_d;
	logic [1:0]           lm_eff;
	logic                 out_valid_q;
	logic [1:0]           kind_q;
	logic [7:0]           pay_q;
	logic [1:0]           err_q;
	logic [LEN_OUT_BITS-1:0] len_q;
	logic                 res_v;
	logic [1:0]           res_kind;
	logic [7:0]           res_pay;
	logic [1:0]           res_err;
	logic [63:0]          tot_ext;
	logic                 advance;

	assign advance = !out_valid_q || result_out.ready;
	assign pop     = advance && q_valid;
	assign tot_ext = 64'(tot_q);
	assign lm_eff  = (st_q == ST_SIZE_CR) ? LM_BAD : lm_q;

	always_comb begin
		st_d     = st_q;
		acc_d    = acc_q;
		left_d   = left_q;
		tot_d    = tot_q;
		seen_d   = seen_q;
		lm_d     = lm_q;
		stop_d   = stop_q;
		res_v    = 1'b0;
		res_kind = KIND_DATA;
		res_pay  = 8'd0;
		res_err  = ERR_NONE;
		if (q_item.restart) begin
			st_d   = ST_SIZE;
			acc_d  = '0;
			left_d = '0;
			tot_d  = '0;
			seen_d = 1'b0;
			lm_d   = LM_GOOD;
			stop_d = 1'b0;
		end else if (!stop_q) begin
			unique case (st_q)
				ST_SIZE, ST_SIZE_CR: begin
					if (st_q == ST_SIZE_CR && q_item.is_lf) begin
						// end of size line
						acc_d  = '0;
						seen_d = 1'b0;
						lm_d   = LM_GOOD;
						if (lm_q == LM_BAD || !seen_q) begin
							stop_d = 1'b1; res_v = 1'b1;
							res_kind = KIND_ERROR; res_err = ERR_BAD_SIZE;
						end else if (lm_q == LM_OVF) begin
							stop_d = 1'b1; res_v = 1'b1;
							res_kind = KIND_ERROR; res_err = ERR_OVERFLOW;
						end else if (acc_q == '0) begin
							st_d = ST_TRAILER;
							lm_d = LM_CRLF;
						end else begin
							st_d   = ST_DATA;
							left_d = acc_q;
						end
					end else begin
						st_d = ST_SIZE;
						lm_d = lm_eff;
						if (q_item.is_cr) begin
							st_d = ST_SIZE_CR;
						end else if (q_item.is_semi) begin
							st_d = ST_EXT;
						end else if (!q_item.is_hex) begin
							lm_d = LM_BAD;
						end else begin
							seen_d = 1'b1;
							if (lm_eff == LM_GOOD) begin
								if (|acc_q[SIZE_BITS-1 -: 4]) begin
									lm_d = LM_OVF;
								end else begin
									acc_d = {acc_q[SIZE_BITS-5:0], q_item.hex_val};
								end
							end
						end
					end
				end
				ST_EXT: begin
					if (q_item.is_cr) begin
						st_d = ST_EXT_CR;
					end
				end
				ST_EXT_CR: begin
					if (q_item.is_lf) begin
						acc_d  = '0;
						seen_d = 1'b0;
						lm_d   = LM_GOOD;
						if (lm_q == LM_BAD || !seen_q) begin
							stop_d = 1'b1; res_v = 1'b1;
							res_kind = KIND_ERROR; res_err = ERR_BAD_SIZE;
						end else if (lm_q == LM_OVF) begin
							stop_d = 1'b1; res_v = 1'b1;
							res_kind = KIND_ERROR; res_err = ERR_OVERFLOW;
						end else if (acc_q == '0) begin
							st_d = ST_TRAILER;
							lm_d = LM_CRLF;
						end else begin
							st_d   = ST_DATA;
							left_d = acc_q;
						end
					end else if (!q_item.is_cr) begin
						st_d = ST_EXT;
					end
				end
				ST_DATA: begin
					tot_d  = tot_q + LENGTH_BITS'(1);
					left_d = left_q - SIZE_BITS'(1);
					if (left_q <= SIZE_BITS'(1)) begin
						left_d = '0;
						st_d   = ST_DATA_CR;
					end
					res_v   = 1'b1;
					res_pay = q_item.data;
				end
				ST_DATA_CR: begin
					lm_d = q_item.is_cr ? LM_CR : LM_NONE;
					st_d = ST_DATA_LF;
				end
				ST_DATA_LF: begin
					lm_d = LM_NONE;
					if (lm_q == LM_CR && q_item.is_lf) begin
						st_d = ST_SIZE;
					end else begin
						stop_d = 1'b1; res_v = 1'b1;
						res_kind = KIND_ERROR; res_err = ERR_DATA_END;
					end
				end
				ST_TRAILER: begin
					if (q_item.is_cr) begin
						lm_d = (lm_q == LM_CRLF) ? LM_CRLFCR : LM_CR;
					end else if (q_item.is_lf && lm_q == LM_CRLFCR) begin
						stop_d   = 1'b1;
						res_v    = 1'b1;
						res_kind = KIND_COMPLETE;
					end else if (q_item.is_lf && lm_q == LM_CR) begin
						lm_d = LM_CRLF;
					end else begin
						lm_d = LM_NONE;
					end
				end
				default: begin
					st_d = ST_SIZE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_SIZE;
			acc_q       <= '0;
			left_q      <= '0;
			tot_q       <= '0;
			seen_q      <= 1'b0;
			lm_q        <= LM_GOOD;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				st_q   <= st_d;
				acc_q  <= acc_d;
				left_q <= left_d;
				tot_q  <= tot_d;
				seen_q <= seen_d;
				lm_q   <= lm_d;
				stop_q <= stop_d;
			end
			if (advance) begin
				out_valid_q <= pop && res_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_v && advance) begin
			kind_q <= res_kind;
			pay_q  <= res_pay;
			err_q  <= res_err;
			len_q  <= (res_kind == KIND_COMPLETE) ? tot_ext[LEN_OUT_BITS-1:0] : '0;
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.kind           = kind_q;
	assign result_out.payload_byte   = pay_q;
	assign result_out.error_code     = err_q;
	assign result_out.decoded_length = len_q;
endmodule

/* rtl/http_chunked_body_decoder.sv */
// HTTP chunked body decoder: one body byte in, at most one result out.
// Uses chb_pkg, chb_in_if, chb_out_if, chb_front, chb_queue and chb_back.
//
// Channels: body_in carries action (0 byte, 1 restart) and data_byte;
// result_out carries kind (payload byte, body complete, error), payload_byte,
// error_code and decoded_length. Both use valid/ready; a transaction moves
// at a rising edge where both are high.
// Throughput: one transaction per cycle on each side while the receiver keeps
// result_out.ready high. The chunk state machine then retires one queued
// byte per cycle; its state update (hex shift-in, byte count, length
// increment) is combinational. An accepted byte is written into the queue,
// then its result is captured in the result register.
// Bytes that make no result (size lines, CRLFs, trailers, bytes after a
// completion or error) are consumed silently. A restart transaction clears
// the decoder state and produces nothing.
// Reset (arst_n low) empties the queue and the result register and puts the
// decoder at the start of a size line.
// When the receiver stalls, the result register holds its transaction, the
// core stops, and the four-entry queue absorbs input until it fills; then
// body_in.ready drops.
module http_chunked_body_decoder
	import chb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	chb_in_if.sink    body_in,
	chb_out_if.source result_out
);
	logic      push;
	chb_item_t push_item;
	logic      q_full;
	logic      pop;
	logic      q_valid;
	chb_item_t q_item;

	// classify and admit input bytes
	chb_front u_front (
		.body_in   (body_in),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// decouple intake from the decoder core
	chb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	// advance the chunk state machine and drive results
	chb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.pop        (pop),
		.result_out (result_out)
	);
endmodule

/* rtl/chb_checker.sv */
// Port-level checks of the chunked body decoder's result channel.
// Depends on chb_pkg; bound to http_chunked_body_decoder below.
module chb_checker
	import chb_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  payload_byte,
	input logic [1:0]  error_code,
	input logic [31:0] decoded_length
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_DATA |-> payload_byte == 8'd0)
		else $error("payload byte set on non-data result");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
		else $error("error code does not match result kind");

	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_COMPLETE |-> decoded_length == 32'd0)
		else $error("length set on non-completion result");
endmodule

bind http_chunked_body_decoder chb_checker u_chb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result_out.valid),
	.out_ready      (result_out.ready),
	.kind           (result_out.kind),
	.payload_byte   (result_out.payload_byte),
	.error_code     (result_out.error_code),
	.decoded_length (result_out.decoded_length)
);
